// File: src/mpwgf_pkg.sv
// ----------------------------------------------------------------------------
// Minimum pulse width glitch filter package
// Shared widths, constants, payload structs and state types.
// ----------------------------------------------------------------------------
package mpwgf_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned MAX_MIN_RUN     = 64;
  localparam int unsigned MIN_RUN_W       = 7;
  localparam int unsigned STAT_W          = 16;
  localparam int unsigned AVG_W           = 24;
  localparam int unsigned FRAC_W          = 8;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MIN_RUN_W-1:0] MIN_RUN_RESET = MIN_RUN_W'(5);

  typedef struct packed {
    logic sample_bit;
    logic last_sample;
  } in_item_t;

  typedef struct packed {
    logic              out_bit;
    logic              out_last;
    logic              stream_done;
    logic [STAT_W-1:0] glitch_count;
    logic [STAT_W-1:0] replaced_count;
    logic [STAT_W-1:0] valid_run_count;
    logic [AVG_W-1:0]  average_run_x256;
    logic              no_valid_runs;
  } out_item_t;

  typedef struct packed {
    logic                 value;
    logic [MIN_RUN_W-1:0] count;
    logic                 tail_zero;
    logic                 last;
    logic [STAT_W-1:0]    glitch;
    logic [STAT_W-1:0]    replaced;
    logic [STAT_W-1:0]    valid_runs;
    logic [AVG_W-1:0]     average;
    logic                 no_valid;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [0:0] {
    FE_RUN,
    FE_DIV
  } front_state_e;

endpackage

// File: src/mpwgf_div.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Produces one quotient bit per cycle for the stream-end average.
// ----------------------------------------------------------------------------
module mpwgf_div #(
  parameter int unsigned CountWidth = mpwgf_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic [CountWidth+mpwgf_pkg::FRAC_W-1:0] dividend_i,
  input  logic [CountWidth-1:0]                  divisor_i,
  output logic                                   busy_o,
  output logic [CountWidth+mpwgf_pkg::FRAC_W-1:0] quotient_o
);
  import mpwgf_pkg::*;

  localparam int unsigned DW     = CountWidth + FRAC_W;
  localparam int unsigned STEP_W = $clog2(DW + 1);

  logic                  busy_q;
  logic [STEP_W-1:0]     step_q;
  logic [CountWidth-1:0] rem_q;
  logic [DW-1:0]         quo_q;
  logic [CountWidth-1:0] dvs_q;
  logic [CountWidth:0]   trial;
  logic [CountWidth:0]   diff;
  logic                  ge;

  assign trial = {rem_q, quo_q[DW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_W'(DW);
    end else if (busy_q) begin
      step_q <= step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[CountWidth-1:0] : trial[CountWidth-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// File: src/mpwgf_front.sv
// ----------------------------------------------------------------------------
// Glitch filter front end
// Accepts samples, tracks the open run and statistics, and issues commands.
// ----------------------------------------------------------------------------
module mpwgf_front #(
  parameter int unsigned CountWidth = mpwgf_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  mpwgf_pkg::in_item_t               in_data_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mpwgf_pkg::MIN_RUN_W-1:0]   cfg_data_i,
  input  mpwgf_pkg::q_status_t              q_status_i,
  output logic                              push_o,
  output mpwgf_pkg::cmd_t                   cmd_o
);
  import mpwgf_pkg::*;

  localparam int unsigned DW = CountWidth + FRAC_W;
  localparam int unsigned QW = (DW > AVG_W) ? DW : AVG_W;

  function automatic logic [CountWidth-1:0] sat_add(input logic [CountWidth-1:0] a,
                                                    input logic [CountWidth-1:0] b);
    logic [CountWidth:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CountWidth] ? {CountWidth{1'b1}} : s[CountWidth-1:0];
  endfunction

  front_state_e          state_q, state_d;
  logic [MIN_RUN_W-1:0]  min_run_q;
  logic [MIN_RUN_W-1:0]  pending_q, pending_d;
  logic                  confirmed_q, confirmed_d;
  logic [CountWidth-1:0] run_len_q, run_len_d;
  logic [CountWidth-1:0] glitch_q, glitch_n;
  logic [CountWidth-1:0] replaced_q, replaced_n;
  logic [CountWidth-1:0] vruns_q, vruns_n;
  logic [CountWidth-1:0] vsum_q, vsum_n;
  cmd_t                  cmd_q;
  cmd_t                  cmd_now;
  cmd_t                  cmd_end;
  cmd_t                  cmd_final;

  logic [MIN_RUN_W-1:0]  eff_min;
  logic [MIN_RUN_W-1:0]  pend_inc;
  logic [MIN_RUN_W-1:0]  pend_c;
  logic                  conf_c;
  logic [CountWidth-1:0] len_c;
  logic [MIN_RUN_W-1:0]  p1_count;
  logic [MIN_RUN_W-1:0]  cl_count;
  logic                  cl_value;
  logic                  do_close;
  logic                  add_valid;
  logic                  add_glitch;
  logic                  accept;
  logic                  div_start;
  logic                  div_busy;
  logic [DW-1:0]         quotient;
  logic [QW-1:0]         quo_ext;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;
  assign div_start   = accept && in_data_i.last_sample;

  always_comb begin
    if (min_run_q == '0) begin
      eff_min = MIN_RUN_W'(1);
    end else if (min_run_q > MIN_RUN_W'(MAX_MIN_RUN)) begin
      eff_min = MIN_RUN_W'(MAX_MIN_RUN);
    end else begin
      eff_min = min_run_q;
    end
  end

  always_comb begin
    pend_inc   = pending_q + MIN_RUN_W'(1);
    pend_c     = pending_q;
    conf_c     = confirmed_q;
    len_c      = run_len_q;
    p1_count   = '0;
    cl_count   = '0;
    cl_value   = 1'b0;
    add_valid  = 1'b0;
    add_glitch = 1'b0;
    if (in_data_i.sample_bit) begin
      len_c = sat_add(run_len_q, CountWidth'(1));
      if (confirmed_q) begin
        p1_count = MIN_RUN_W'(1);
      end else if (pend_inc >= eff_min) begin
        p1_count = pend_inc;
        pend_c   = '0;
        conf_c   = 1'b1;
      end else begin
        pend_c = pend_inc;
      end
    end
    do_close = !in_data_i.sample_bit || in_data_i.last_sample;
    if (do_close) begin
      if (conf_c) begin
        add_valid = 1'b1;
      end else if (pend_c != '0) begin
        cl_count = pend_c;
        if (pend_c >= eff_min) begin
          cl_value  = 1'b1;
          add_valid = 1'b1;
        end else begin
          add_glitch = 1'b1;
        end
      end
    end

    vruns_n    = add_valid ? sat_add(vruns_q, CountWidth'(1)) : vruns_q;
    vsum_n     = add_valid ? sat_add(vsum_q, len_c) : vsum_q;
    glitch_n   = add_glitch ? sat_add(glitch_q, CountWidth'(1)) : glitch_q;
    replaced_n = add_glitch ? sat_add(replaced_q, CountWidth'(pend_c)) : replaced_q;

    pending_d   = do_close ? '0 : pend_c;
    confirmed_d = do_close ? 1'b0 : conf_c;
    run_len_d   = do_close ? '0 : len_c;

    cmd_now           = '0;
    cmd_now.value     = (p1_count != '0) ? 1'b1 : cl_value;
    cmd_now.count     = (p1_count != '0) ? p1_count : cl_count;
    cmd_now.tail_zero = !in_data_i.sample_bit;
  end

  always_comb begin
    cmd_end            = cmd_now;
    cmd_end.last       = 1'b1;
    cmd_end.glitch     = STAT_W'(glitch_n);
    cmd_end.replaced   = STAT_W'(replaced_n);
    cmd_end.valid_runs = STAT_W'(vruns_n);
    cmd_end.no_valid   = (vruns_n == '0);
  end

  always_comb begin
    quo_ext           = QW'(quotient);
    cmd_final         = cmd_q;
    if (cmd_q.no_valid) begin
      cmd_final.average = '0;
    end else if (quo_ext > QW'({AVG_W{1'b1}})) begin
      cmd_final.average = {AVG_W{1'b1}};
    end else begin
      cmd_final.average = quo_ext[AVG_W-1:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    push_o     = 1'b0;
    cmd_o      = cmd_now;
    case (state_q)
      FE_RUN: begin
        in_stall_o = q_status_i.full;
        push_o     = accept && !in_data_i.last_sample &&
                     ((cmd_now.count != '0) || cmd_now.tail_zero);
        if (div_start) begin
          state_d = FE_DIV;
        end
      end
      FE_DIV: begin
        cmd_o = cmd_final;
        if (!div_busy && !q_status_i.full) begin
          push_o  = 1'b1;
          state_d = FE_RUN;
        end
      end
      default: begin
        state_d = FE_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_run_q   <= MIN_RUN_RESET;
      pending_q   <= '0;
      confirmed_q <= 1'b0;
      run_len_q   <= '0;
      glitch_q    <= '0;
      replaced_q  <= '0;
      vruns_q     <= '0;
      vsum_q      <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        min_run_q <= cfg_data_i;
      end
      if (accept) begin
        pending_q   <= pending_d;
        confirmed_q <= confirmed_d;
        run_len_q   <= run_len_d;
        if (in_data_i.last_sample) begin
          glitch_q   <= '0;
          replaced_q <= '0;
          vruns_q    <= '0;
          vsum_q     <= '0;
        end else begin
          glitch_q   <= glitch_n;
          replaced_q <= replaced_n;
          vruns_q    <= vruns_n;
          vsum_q     <= vsum_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      cmd_q <= cmd_end;
    end
  end

  mpwgf_div #(
    .CountWidth(CountWidth)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({vsum_n, FRAC_W'(0)}),
    .divisor_i (vruns_n),
    .busy_o    (div_busy),
    .quotient_o(quotient)
  );

`ifndef ASSERT_OFF
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q < MIN_RUN_W'(MAX_MIN_RUN))
    else $error("Held run is longer than the largest minimum.");

  a_confirmed_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    confirmed_q |-> (pending_q == '0))
    else $error("Confirmed run still holds ones.");
`endif

endmodule

// File: src/mpwgf_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO that decouples the front end from the output sequencer.
// ----------------------------------------------------------------------------
module mpwgf_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mpwgf_pkg::cmd_t      data_i,
  input  logic                 pop_i,
  output mpwgf_pkg::cmd_t      data_o,
  output mpwgf_pkg::q_status_t status_o
);
  import mpwgf_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign status_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign data_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("Command pushed into a full queue.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("Command popped from an empty queue.");
`endif

endmodule

// File: src/mpwgf_back.sv
// ----------------------------------------------------------------------------
// Output sequencer
// Expands each command into result items through an output register.
// ----------------------------------------------------------------------------
module mpwgf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mpwgf_pkg::cmd_t      cmd_i,
  input  mpwgf_pkg::q_status_t q_status_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mpwgf_pkg::out_item_t out_data_o
);
  import mpwgf_pkg::*;

  logic [MIN_RUN_W-1:0] pos_q;
  logic [MIN_RUN_W-1:0] total;
  logic                 final_bit;
  logic                 load;
  logic                 done;
  logic                 out_valid_q;
  out_item_t            out_q;
  out_item_t            out_d;

  assign total     = cmd_i.count + MIN_RUN_W'(cmd_i.tail_zero);
  assign final_bit = (pos_q + MIN_RUN_W'(1)) == total;
  assign load      = !q_status_i.empty && (!out_valid_q || !out_stall_i);
  assign pop_o     = load && final_bit;
  assign done      = final_bit && cmd_i.last;

  always_comb begin
    out_d             = '0;
    out_d.out_bit     = (pos_q < cmd_i.count) ? cmd_i.value : 1'b0;
    out_d.out_last    = final_bit;
    out_d.stream_done = done;
    if (done) begin
      out_d.glitch_count     = cmd_i.glitch;
      out_d.replaced_count   = cmd_i.replaced;
      out_d.valid_run_count  = cmd_i.valid_runs;
      out_d.average_run_x256 = cmd_i.average;
      out_d.no_valid_runs    = cmd_i.no_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        pos_q       <= final_bit ? '0 : pos_q + MIN_RUN_W'(1);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_status_i.empty |-> (pos_q < total))
    else $error("Result position runs past the queued command.");
`endif

endmodule

// File: src/min_pulse_width_glitch_filter.sv
// ----------------------------------------------------------------------------
// Minimum pulse width glitch filter: a sample is taken per cycle while the queue has room,
// except that a stream's final sample holds input until its average is divided and pushed.
// Results pass the queue and the output register and flow one per cycle unless stalled.
// Reset clears run state and statistics and sets min_run to 5; no clearing pass is needed.
// ----------------------------------------------------------------------------
module min_pulse_width_glitch_filter #(
  parameter int unsigned CountWidth = mpwgf_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  mpwgf_pkg::in_item_t             in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output mpwgf_pkg::out_item_t            out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mpwgf_pkg::MIN_RUN_W-1:0] cfg_data_i
);
  import mpwgf_pkg::*;

  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      head_cmd;
  q_status_t q_status;

  mpwgf_front #(
    .CountWidth(CountWidth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  mpwgf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .pop_i   (pop),
    .data_o  (head_cmd),
    .status_o(q_status)
  );

  mpwgf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (head_cmd),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// File: tb/sv/min_pulse_width_glitch_filter_tb.sv
// ----------------------------------------------------------------------------
// Minimum pulse width glitch filter testbench
// Drives sample requests and min_run writes, and predicts every filtered sample
// and the stream statistics. Each accepted result is checked against the oldest
// prediction. Phases vary min_run, sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module min_pulse_width_glitch_filter_tb;
  import mpwgf_pkg::*;

  class pulse_filter_scoreboard;
    logic [MIN_RUN_W-1:0] min_run;
    int unsigned          held_ones;
    bit                   run_locked;
    logic [STAT_W-1:0]    run_len;
    logic [STAT_W-1:0]    glitches;
    logic [STAT_W-1:0]    replaced;
    logic [STAT_W-1:0]    valid_runs;
    logic [STAT_W-1:0]    valid_len_sum;
    out_item_t            burst_q[$];
    out_item_t            filtered_q[$];
    int unsigned          errors;
    int unsigned          checked;
    int unsigned          streams;
    int unsigned          writes;

    function new();
      min_run       = MIN_RUN_RESET;
      held_ones     = 0;
      run_locked    = 1'b0;
      run_len       = '0;
      glitches      = '0;
      replaced      = '0;
      valid_runs    = '0;
      valid_len_sum = '0;
      errors        = 0;
      checked       = 0;
      streams       = 0;
      writes        = 0;
    endfunction

    function int unsigned outstanding();
      return filtered_q.size();
    endfunction

    function void set_min_run(logic [MIN_RUN_W-1:0] value);
      min_run = value;
      writes++;
    endfunction

    function int unsigned eff_min();
      int unsigned m;
      m = min_run;
      if (m == 0) m = 1;
      if (m > MAX_MIN_RUN) m = MAX_MIN_RUN;
      return m;
    endfunction

    function logic [STAT_W-1:0] sat_add(logic [STAT_W-1:0] a, logic [STAT_W-1:0] b);
      logic [STAT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[STAT_W] ? '1 : s[STAT_W-1:0];
    endfunction

    function void push(logic value);
      out_item_t r;
      r = '0;
      r.out_bit = value;
      burst_q.push_back(r);
    endfunction

    function void count_valid();
      valid_runs    = sat_add(valid_runs, STAT_W'(1));
      valid_len_sum = sat_add(valid_len_sum, run_len);
    endfunction

    function void end_run();
      if (run_locked) begin
        count_valid();
      end else if (held_ones != 0) begin
        if (held_ones >= eff_min()) begin
          repeat (held_ones) push(1'b1);
          count_valid();
        end else begin
          repeat (held_ones) push(1'b0);
          glitches = sat_add(glitches, STAT_W'(1));
          replaced = sat_add(replaced, STAT_W'(held_ones));
        end
      end
      held_ones  = 0;
      run_locked = 1'b0;
      run_len    = '0;
    endfunction

    function void note_sample(in_item_t req);
      out_item_t   tail;
      logic [63:0] avg;
      burst_q.delete();
      if (req.sample_bit) begin
        run_len = sat_add(run_len, STAT_W'(1));
        if (run_locked) begin
          push(1'b1);
        end else begin
          held_ones++;
          if (held_ones >= eff_min()) begin
            repeat (held_ones) push(1'b1);
            held_ones  = 0;
            run_locked = 1'b1;
          end
        end
        if (req.last_sample) end_run();
      end else begin
        end_run();
        push(1'b0);
      end
      if (burst_q.size() != 0) begin
        tail = burst_q[burst_q.size()-1];
        tail.out_last = 1'b1;
        if (req.last_sample) begin
          tail.stream_done     = 1'b1;
          tail.glitch_count    = glitches;
          tail.replaced_count  = replaced;
          tail.valid_run_count = valid_runs;
          if (valid_runs != 0) begin
            avg = (64'(valid_len_sum) << FRAC_W) / 64'(valid_runs);
            if (avg > 64'({AVG_W{1'b1}})) avg = 64'({AVG_W{1'b1}});
            tail.average_run_x256 = AVG_W'(avg);
            tail.no_valid_runs    = 1'b0;
          end else begin
            tail.average_run_x256 = '0;
            tail.no_valid_runs    = 1'b1;
          end
          glitches      = '0;
          replaced      = '0;
          valid_runs    = '0;
          valid_len_sum = '0;
          streams++;
        end
        burst_q[burst_q.size()-1] = tail;
        foreach (burst_q[i]) filtered_q.push_back(burst_q[i]);
      end
    endfunction

    function void compare_field(string name, logic [AVG_W-1:0] want, logic [AVG_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_filtered(out_item_t got);
      out_item_t want;
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = filtered_q.pop_front();
      checked++;
      compare_field("out_bit", AVG_W'(want.out_bit), AVG_W'(got.out_bit));
      compare_field("out_last", AVG_W'(want.out_last), AVG_W'(got.out_last));
      compare_field("stream_done", AVG_W'(want.stream_done), AVG_W'(got.stream_done));
      compare_field("glitch_count", AVG_W'(want.glitch_count), AVG_W'(got.glitch_count));
      compare_field("replaced_count", AVG_W'(want.replaced_count),
                    AVG_W'(got.replaced_count));
      compare_field("valid_run_count", AVG_W'(want.valid_run_count),
                    AVG_W'(got.valid_run_count));
      compare_field("average_run_x256", want.average_run_x256, got.average_run_x256);
      compare_field("no_valid_runs", AVG_W'(want.no_valid_runs), AVG_W'(got.no_valid_runs));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  in_item_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  out_item_t            out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [MIN_RUN_W-1:0] cfg_data_i;

  pulse_filter_scoreboard sb = new();

  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned items_sent      = 0;

  min_pulse_width_glitch_filter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles != 0) begin
        out_stall_i <= 1'b1;
        hold_off_cycles--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_min_run(cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.note_sample(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_filtered(out_data_o);
    end
  end

  task automatic send_sample(input logic bit_v, input logic last_v);
    in_item_t    req;
    int unsigned gap;
    req.sample_bit  = bit_v;
    req.last_sample = last_v;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_min_run(input logic [MIN_RUN_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned n_items, input int unsigned idle_pct,
                           input int unsigned stall_pct, input bit hold_off,
                           input int unsigned lead_len);
    int unsigned m;
    int unsigned run_len;
    int unsigned runs;
    int unsigned start;
    bit          hold_done;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    m         = sb.eff_min();
    runs      = 0;
    hold_done = 1'b0;
    start     = items_sent;
    while (items_sent - start < n_items) begin
      if (hold_off && !hold_done && items_sent - start >= 8) begin
        hold_off_cycles = 300;
        hold_done       = 1'b1;
      end
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 4))
          send_sample(1'($urandom_range(1)), 1'($urandom_range(15) == 0));
      end else begin
        if (runs == 0 && lead_len != 0) begin
          run_len = lead_len;
        end else begin
          case ($urandom_range(3))
            0: run_len = m - 1;
            1: run_len = m;
            2: run_len = m + $urandom_range(1, 3);
            default: run_len = $urandom_range(1, m + 1);
          endcase
        end
        runs++;
        repeat ($urandom_range(1, 3)) send_sample(1'b0, 1'($urandom_range(15) == 0));
        repeat (run_len) send_sample(1'b1, 1'(runs > 1 && $urandom_range(31) == 0));
      end
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The reset value of min_run is five.
    send_sample(1'b0, 1'b0);
    repeat (4) send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b0);
    repeat (6) send_sample(1'b1, 1'b0);
    send_sample(1'b0, 1'b0);
    repeat (2) send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b1);
    send_sample(1'b0, 1'b1);

    // Lower min_run while ones are held back.
    repeat (3) send_sample(1'b1, 1'b0);
    settle();
    write_min_run(7'd3);
    send_sample(1'b0, 1'b1);
    repeat (2) send_sample(1'b1, 1'b0);
    settle();
    write_min_run('0);
    send_sample(1'b1, 1'b0);
    send_sample(1'b1, 1'b1);

    settle();
    write_min_run(7'd1);
    run_phase(30, 0, 0, 1'b1, 0);
    settle();
    write_min_run(7'($urandom_range(2, 9)));
    run_phase(30, 83, 0, 1'b0, 0);
    settle();
    write_min_run('1);
    run_phase(40, 0, 83, 1'b0, MAX_MIN_RUN - 1);
    settle();
    write_min_run(7'(MAX_MIN_RUN));
    run_phase(20, 24, 24, 1'b0, MAX_MIN_RUN);
    settle();
    write_min_run(7'($urandom_range(0, 12)));
    run_phase(30, 0, 83, 1'b0, 0);
    settle();

    $display("Sent %0d samples over %0d closed streams and %0d min_run writes.",
             items_sent, sb.streams, sb.writes);
    $display("Compared %0d filtered samples, %0d field errors.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("%0t: timeout with %0d results outstanding", $time, sb.outstanding());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: sim.f
src/mpwgf_pkg.sv
src/mpwgf_div.sv
src/mpwgf_front.sv
src/mpwgf_queue.sv
src/mpwgf_back.sv
src/min_pulse_width_glitch_filter.sv
tb/sv/min_pulse_width_glitch_filter_tb.sv
